@@ hdl/lcat_pkg.sv @@
// ----------------------------------------------------------------------------
// lcat_pkg
// Shared constants, types and helpers of the lowest common ancestor table.
// ----------------------------------------------------------------------------
package lcat_pkg;

  localparam int ID_BITS    = 16;
  localparam int MAX_LEVEL  = 255;
  localparam int ID_W       = 16;
  localparam int LEVEL_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int TABLE_SIZE = 2 ** ID_BITS;
  localparam int STEP_BITS  = $clog2(MAX_LEVEL + 1);

  typedef logic [ID_BITS-1:0]   idx_t;
  typedef logic [ID_W-1:0]      id_t;
  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam logic    KIND_WRITE = 1'b0;
  localparam logic    KIND_QUERY = 1'b1;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_UNKNOWN = 2'd1;
  localparam status_t ST_BOUND   = 2'd2;

  localparam logic [2:0] RD_NONE = 3'd0;
  localparam logic [2:0] RD_A    = 3'd1;
  localparam logic [2:0] RD_B    = 3'd2;
  localparam logic [2:0] RD_P1   = 3'd3;
  localparam logic [2:0] RD_P2   = 3'd4;

  localparam logic [2:0] CAP_NONE = 3'd0;
  localparam logic [2:0] CAP_A    = 3'd1;
  localparam logic [2:0] CAP_B    = 3'd2;
  localparam logic [2:0] CAP_1    = 3'd3;
  localparam logic [2:0] CAP_2    = 3'd4;

  typedef struct packed {
    logic   valid;
    level_t level;
    id_t    parent;
  } entry_t;

  typedef struct packed {
    logic       clr_en;
    logic       wr_en;
    logic       load;
    logic [2:0] rd_sel;
    logic [2:0] cap_sel;
    logic       step_inc;
    logic       set_anc;
    logic       fin_en;
    status_t    fin_code;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_ok;
    logic a_rng;
    logic b_rng;
    logic p1_rng;
    logic p2_rng;
    logic l1_gt;
    logic l2_gt;
    logic t_eq;
    logic steps_max;
    logic out_free;
  } stat_t;

  function automatic logic id_in_range(id_t id);
    logic r;
    if (ID_BITS >= ID_W) begin
      r = 1'b1;
    end else begin
      r = ((id >> ID_BITS) == '0);
    end
    return r;
  endfunction

  function automatic idx_t to_idx(id_t id);
    return idx_t'(id);
  endfunction

endpackage

@@ hdl/lcat_if.sv @@
// ----------------------------------------------------------------------------
// lcat_if
// Valid/ready channels of the lowest common ancestor table.
// ----------------------------------------------------------------------------
interface lcat_req_if;
  logic                 valid;
  logic                 ready;
  logic                 kind;
  lcat_pkg::id_t        id_a;
  lcat_pkg::id_t        id_b;
  lcat_pkg::level_t     depth_level;

  modport source (output valid, kind, id_a, id_b, depth_level, input ready);
  modport sink   (input valid, kind, id_a, id_b, depth_level, output ready);
endinterface

interface lcat_rsp_if;
  logic                 valid;
  logic                 ready;
  lcat_pkg::id_t        common_ancestor;
  logic                 a_is_ancestor;
  lcat_pkg::status_t    status;

  modport source (output valid, common_ancestor, a_is_ancestor, status, input ready);
  modport sink   (input valid, common_ancestor, a_is_ancestor, status, output ready);
endinterface

@@ hdl/lcat_ctrl.sv @@
// ----------------------------------------------------------------------------
// lcat_ctrl
// Sequencer: table clear, writes, query read-out and the parent walk.
// ----------------------------------------------------------------------------
module lcat_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic            req_kind,
  output logic            req_ready,
  input  lcat_pkg::stat_t stat,
  output lcat_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RDA   = 4'd2;
  localparam logic [3:0] S_CHKA  = 4'd3;
  localparam logic [3:0] S_CHKB  = 4'd4;
  localparam logic [3:0] S_STEP  = 4'd5;
  localparam logic [3:0] S_CHK1  = 4'd6;
  localparam logic [3:0] S_CHK2  = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;

  localparam logic [1:0] PH_LIFT1 = 2'd0;
  localparam logic [1:0] PH_LIFT2 = 2'd1;
  localparam logic [1:0] PH_JOINT = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      phase <= PH_LIFT1;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    req_ready  = 1'b0;
    cmd        = '0;
    cmd.rd_sel  = lcat_pkg::RD_NONE;
    cmd.cap_sel = lcat_pkg::CAP_NONE;
    cmd.fin_code = lcat_pkg::ST_OK;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_kind == lcat_pkg::KIND_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_RDA;
          end
        end
      end
      S_RDA: begin
        if (!stat.a_rng) begin
          cmd.fin_en   = 1'b1;
          cmd.fin_code = lcat_pkg::ST_UNKNOWN;
          state_next   = S_DONE;
        end else begin
          cmd.rd_sel = lcat_pkg::RD_A;
          state_next = S_CHKA;
        end
      end
      S_CHKA: begin
        if (!stat.rd_ok || !stat.b_rng) begin
          cmd.fin_en   = 1'b1;
          cmd.fin_code = lcat_pkg::ST_UNKNOWN;
          state_next   = S_DONE;
        end else begin
          cmd.cap_sel = lcat_pkg::CAP_A;
          cmd.rd_sel  = lcat_pkg::RD_B;
          state_next  = S_CHKB;
        end
      end
      S_CHKB: begin
        if (!stat.rd_ok) begin
          cmd.fin_en   = 1'b1;
          cmd.fin_code = lcat_pkg::ST_UNKNOWN;
          state_next   = S_DONE;
        end else begin
          cmd.cap_sel = lcat_pkg::CAP_B;
          phase_next  = PH_LIFT1;
          state_next  = S_STEP;
        end
      end
      S_STEP: begin
        case (phase)
          PH_LIFT1: begin
            if (!stat.l1_gt) begin
              phase_next = PH_LIFT2;
            end else if (stat.steps_max) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_BOUND;
              state_next   = S_DONE;
            end else if (!stat.p1_rng) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_UNKNOWN;
              state_next   = S_DONE;
            end else begin
              cmd.step_inc = 1'b1;
              cmd.rd_sel   = lcat_pkg::RD_P1;
              state_next   = S_CHK1;
            end
          end
          PH_LIFT2: begin
            if (!stat.l2_gt) begin
              cmd.set_anc = 1'b1;
              phase_next  = PH_JOINT;
            end else if (stat.steps_max) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_BOUND;
              state_next   = S_DONE;
            end else if (!stat.p2_rng) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_UNKNOWN;
              state_next   = S_DONE;
            end else begin
              cmd.step_inc = 1'b1;
              cmd.rd_sel   = lcat_pkg::RD_P2;
              state_next   = S_CHK2;
            end
          end
          default: begin
            if (stat.t_eq) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_OK;
              state_next   = S_DONE;
            end else if (stat.steps_max) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_BOUND;
              state_next   = S_DONE;
            end else if (!stat.p1_rng) begin
              cmd.fin_en   = 1'b1;
              cmd.fin_code = lcat_pkg::ST_UNKNOWN;
              state_next   = S_DONE;
            end else begin
              cmd.step_inc = 1'b1;
              cmd.rd_sel   = lcat_pkg::RD_P1;
              state_next   = S_CHK1;
            end
          end
        endcase
      end
      S_CHK1: begin
        if (!stat.rd_ok) begin
          cmd.fin_en   = 1'b1;
          cmd.fin_code = lcat_pkg::ST_UNKNOWN;
          state_next   = S_DONE;
        end else begin
          cmd.cap_sel = lcat_pkg::CAP_1;
          if (phase != PH_JOINT) begin
            state_next = S_STEP;
          end else if (!stat.p2_rng) begin
            cmd.fin_en   = 1'b1;
            cmd.fin_code = lcat_pkg::ST_UNKNOWN;
            state_next   = S_DONE;
          end else begin
            cmd.rd_sel = lcat_pkg::RD_P2;
            state_next = S_CHK2;
          end
        end
      end
      S_CHK2: begin
        if (!stat.rd_ok) begin
          cmd.fin_en   = 1'b1;
          cmd.fin_code = lcat_pkg::ST_UNKNOWN;
          state_next   = S_DONE;
        end else begin
          cmd.cap_sel = lcat_pkg::CAP_2;
          state_next  = S_STEP;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/lcat_dp.sv @@
// ----------------------------------------------------------------------------
// lcat_dp
// Node table memory, walk registers, step counter and result register.
// ----------------------------------------------------------------------------
module lcat_dp (
  input  logic              clk,
  input  logic              rst,
  input  lcat_pkg::cmd_t    cmd,
  output lcat_pkg::stat_t   stat,
  input  lcat_pkg::id_t     id_a,
  input  lcat_pkg::id_t     id_b,
  input  lcat_pkg::level_t  depth_level,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output lcat_pkg::id_t     common_ancestor,
  output logic              a_is_ancestor,
  output lcat_pkg::status_t status
);

  lcat_pkg::entry_t  mem [lcat_pkg::TABLE_SIZE];
  lcat_pkg::entry_t  rdata;
  lcat_pkg::idx_t    raddr;
  lcat_pkg::idx_t    clr_addr;

  lcat_pkg::id_t     qa, qb, t1, t2, p1, p2;
  lcat_pkg::level_t  l1, l2, la, lb;
  lcat_pkg::step_t   steps;
  logic              anc;
  lcat_pkg::id_t     res_anc;
  logic              res_flag;
  lcat_pkg::status_t res_status;

  always_comb begin
    case (cmd.rd_sel)
      lcat_pkg::RD_A:  raddr = lcat_pkg::to_idx(qa);
      lcat_pkg::RD_B:  raddr = lcat_pkg::to_idx(qb);
      lcat_pkg::RD_P1: raddr = lcat_pkg::to_idx(p1);
      lcat_pkg::RD_P2: raddr = lcat_pkg::to_idx(p2);
      default:         raddr = lcat_pkg::to_idx(qa);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.wr_en && lcat_pkg::id_in_range(id_a)) begin
      mem[lcat_pkg::to_idx(id_a)] <= '{valid: 1'b1, level: depth_level, parent: id_b};
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clr_en) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qa    <= id_a;
      qb    <= id_b;
      t1    <= id_a;
      t2    <= id_b;
      steps <= '0;
    end
    if (cmd.step_inc) steps <= steps + 1'b1;
    case (cmd.cap_sel)
      lcat_pkg::CAP_A: begin
        l1 <= rdata.level;
        la <= rdata.level;
        p1 <= rdata.parent;
      end
      lcat_pkg::CAP_B: begin
        l2 <= rdata.level;
        lb <= rdata.level;
        p2 <= rdata.parent;
      end
      lcat_pkg::CAP_1: begin
        t1 <= p1;
        l1 <= rdata.level;
        p1 <= rdata.parent;
      end
      lcat_pkg::CAP_2: begin
        t2 <= p2;
        l2 <= rdata.level;
        p2 <= rdata.parent;
      end
      default: begin
      end
    endcase
    if (cmd.set_anc) anc <= (la < lb) ? (t2 == qa) : (qa == qb);
    if (cmd.fin_en) begin
      res_status <= cmd.fin_code;
      if (cmd.fin_code == lcat_pkg::ST_OK) begin
        res_anc  <= t1;
        res_flag <= anc;
      end else begin
        res_anc  <= '0;
        res_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      common_ancestor <= res_anc;
      a_is_ancestor   <= res_flag;
      status          <= res_status;
    end
  end

  always_comb begin
    stat.clr_last  = (clr_addr == '1);
    stat.rd_ok     = rdata.valid;
    stat.a_rng     = lcat_pkg::id_in_range(qa);
    stat.b_rng     = lcat_pkg::id_in_range(qb);
    stat.p1_rng    = lcat_pkg::id_in_range(p1);
    stat.p2_rng    = lcat_pkg::id_in_range(p2);
    stat.l1_gt     = (l1 > l2);
    stat.l2_gt     = (l2 > l1);
    stat.t_eq      = (t1 == t2);
    stat.steps_max = (steps >= lcat_pkg::step_t'(lcat_pkg::MAX_LEVEL));
    stat.out_free  = !rsp_valid || rsp_ready;
  end

endmodule

@@ hdl/lowest_common_ancestor_table_top.sv @@
// ----------------------------------------------------------------------------
// lowest_common_ancestor_table_top
// Node table of parent id and depth level with a common ancestor query.
// ----------------------------------------------------------------------------
// After reset the table is cleared one entry per cycle, all 2^ID_BITS entries
// (65536), with req.ready low. A write item is then taken in idle, which stays
// ready for the next item. A query reads both nodes, then walks the table
// through its single read port: a lift step reads one parent, a joint step
// the parents of both nodes, until the lift phases close and the match is
// found; the result register is then loaded once rsp is free; the walk is
// capped at MAX_LEVEL steps. The next item is taken while a result waits on rsp.
module lowest_common_ancestor_table_top (
  input  logic       clk,
  input  logic       rst,
  lcat_req_if.sink   req,
  lcat_rsp_if.source rsp
);

  lcat_pkg::cmd_t  cmd;
  lcat_pkg::stat_t stat;

  lcat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.kind),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lcat_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .id_a            (req.id_a),
    .id_b            (req.id_b),
    .depth_level     (req.depth_level),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .common_ancestor (rsp.common_ancestor),
    .a_is_ancestor   (rsp.a_is_ancestor),
    .status          (rsp.status)
  );

endmodule
